// ===== rtl/p2h_pkg.sv =====
// Package: shared constants, types and fixed-point helpers for the pose-to-matrix block.
`default_nettype none
package p2h_pkg;

   localparam logic [31:0] CK_GAIN_Q30 = 32'd652032874;
   localparam int Q30_FRAC = 30;

   localparam logic [31:0] ATAN_TURN32 [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // pose beat as carried by the input channel
   typedef struct packed {
      logic              operation;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
   } pose_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/pose_to_homogeneous_matrix.sv =====
// Top level: pose in, three matrix rows out over a stream interface.
//
// Usage: one pose beat on req_ (operation, offsets, Z-Y-X angles) yields three
// beats on rsp_, rows 0, 1, 2 of the 3x4 upper part of the homogeneous matrix;
// rsp_tlast marks row 2, rsp_tuser carries the row index.
// Pipeline: angle fold, CORDIC_STAGES (at most 32) micro-rotation stages, rounding,
// then four matrix stages into the row serializer, with a pose delay line beside the CORDIC.
// Rate: the serializer emits three rows per pose on the single result port, so
// it bounds the pose rate; the pipeline itself takes a beat per cycle unless stalled.
// Stall: the whole pipeline advances only when its last stage can move; a
// stalled receiver freezes it and no beat is lost or repeated.
// Reset: synchronous, active high; clears valid bits and the row counter.
`default_nettype none
module pose_to_homogeneous_matrix #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // operation, offset_x, offset_y, offset_z, z_angle, y_angle, x_angle (low to high)
   input  wire logic [151:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // entry_col0, entry_col1, entry_col2, entry_col3 (low to high)
   output logic [127:0]      rsp_tdata,
   // row_index
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import p2h_pkg::*;

   localparam int NST   = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
   localparam int DEPTH = NST + 6;

   pose_type in_pose;
   logic [ANGLE_BITS-1:0] za, ya, xa;

   always_comb begin
      in_pose.operation = req_tdata[0];
      in_pose.offset_x  = req_tdata[32:1];
      in_pose.offset_y  = req_tdata[64:33];
      in_pose.offset_z  = req_tdata[96:65];
      za = ANGLE_BITS'(req_tdata[112:97]);
      ya = ANGLE_BITS'(req_tdata[128:113]);
      xa = ANGLE_BITS'(req_tdata[144:129]);
   end

   // output row buffer and pipeline enable
   logic              hold_ff;
   logic [1:0]        row_ff;
   logic signed [31:0] mat_ff [3][4];
   logic              busy_after;
   logic              enable;
   logic [DEPTH-1:0]  vld_ff;
   logic              done_row2;

   assign done_row2  = hold_ff && rsp_tready && (row_ff == 2'd2);
   assign busy_after = hold_ff && !done_row2;
   assign enable     = !(vld_ff[DEPTH-1] && busy_after);
   assign req_tready = enable;

   // offsets travel beside the CORDIC
   pose_type pose_ff [NST+2];
   always_ff @(posedge clock) begin
      if (enable) begin
         pose_ff[0] <= in_pose;
         for (int i = 1; i < NST + 2; i++) pose_ff[i] <= pose_ff[i-1];
      end
   end

   logic signed [31:0] sz, cz, sp, cp, sx, cx;

   p2h_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES),
                .FRAC_BITS(FRAC_BITS)) u_cz (
      .clock(clock), .enable(enable), .angle(za), .sin_out(sz), .cos_out(cz));
   p2h_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES),
                .FRAC_BITS(FRAC_BITS)) u_cy (
      .clock(clock), .enable(enable), .angle(ya), .sin_out(sp), .cos_out(cp));
   p2h_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES),
                .FRAC_BITS(FRAC_BITS)) u_cx (
      .clock(clock), .enable(enable), .angle(xa), .sin_out(sx), .cos_out(cx));

   logic signed [31:0] mat_w [3][4];

   p2h_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
      .clock(clock), .enable(enable), .pose(pose_ff[NST+1]),
      .sz(sz), .cz(cz), .sp(sp), .cp(cp), .sx(sx), .cx(cx), .mat_out(mat_w));

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // row serializer
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         row_ff  <= '0;
      end else begin
         if (hold_ff && rsp_tready) begin
            row_ff <= (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
            if (row_ff == 2'd2) hold_ff <= 1'b0;
         end
         if (enable && vld_ff[DEPTH-1]) begin
            hold_ff <= 1'b1;
            row_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable && vld_ff[DEPTH-1]) mat_ff <= mat_w;
   end

   assign rsp_tvalid = hold_ff;
   assign rsp_tuser  = row_ff;
   assign rsp_tlast  = (row_ff == 2'd2);
   assign rsp_tdata  = {mat_ff[row_ff][3], mat_ff[row_ff][2],
                        mat_ff[row_ff][1], mat_ff[row_ff][0]};

endmodule
`default_nettype wire

// ===== rtl/p2h_cordic.sv =====
// Pipelined rotation-mode CORDIC: one stage per register, emits sin and cos.
`default_nettype none
module p2h_cordic #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [ANGLE_BITS-1:0] angle,
   output logic signed [31:0]         sin_out,
   output logic signed [31:0]         cos_out
);
   import p2h_pkg::*;

   localparam int NST = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
   localparam int SH  = Q30_FRAC - FRAC_BITS;

   logic signed [33:0] x_ff [NST+1];
   logic signed [33:0] y_ff [NST+1];
   logic signed [32:0] z_ff [NST+1];
   logic               flip_ff [NST+1];

   logic [31:0] a32;
   logic        quad_flip;
   logic [31:0] a_fold;

   // quadrant fold into the right half-plane
   always_comb begin
      a32       = 32'(angle) << (32 - ANGLE_BITS);
      quad_flip = (a32 >= 32'h40000000) && (a32 < 32'hC0000000);
      a_fold    = quad_flip ? (a32 - 32'h80000000) : a32;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= 34'(CK_GAIN_Q30);
         y_ff[0]    <= '0;
         z_ff[0]    <= 33'(signed'(a_fold));
         flip_ff[0] <= quad_flip;
      end
   end

   // micro-rotation stages
   for (genvar i = 0; i < NST; i++) begin : g_st
      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][32]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - 33'(ATAN_TURN32[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + 33'(ATAN_TURN32[i]);
            end
         end
      end
   end

   logic signed [34:0] xs, ys, xr, yr;

   // sign restore and round to FRAC_BITS
   always_comb begin
      xs = flip_ff[NST] ? -35'(x_ff[NST]) : 35'(x_ff[NST]);
      ys = flip_ff[NST] ? -35'(y_ff[NST]) : 35'(y_ff[NST]);
      xr = (xs + (35'sd1 <<< (SH - 1))) >>> SH;
      yr = (ys + (35'sd1 <<< (SH - 1))) >>> SH;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_out <= yr[31:0];
         cos_out <= xr[31:0];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/p2h_matrix.sv =====
// Matrix builder: rotation products and, when operation is set, transpose and inverse translation, pipelined.
`default_nettype none
module p2h_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire p2h_pkg::pose_type    pose,
   input  wire logic signed [31:0]   sz, cz, sp, cp, sx, cx,
   output logic signed [31:0]        mat_out [3][4]
);
   import p2h_pkg::*;

   function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // stage A: first-level products
   // cz*sp and sz*sp stay within about one unit, so 32 bits hold them
   logic signed [31:0] a_czsp_ff, a_szsp_ff;
   logic signed [63:0] a_czcp_ff, a_szcp_ff;
   logic signed [63:0] a_szcx_ff, a_szsx_ff, a_czcx_ff, a_czsx_ff;
   logic signed [63:0] a_cpsx_ff, a_cpcx_ff, a_msp_ff;
   logic signed [31:0] a_sx_ff, a_cx_ff;
   pose_type           a_pose_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         a_czsp_ff <= 32'(fmul(64'(cz), 64'(sp)));
         a_szsp_ff <= 32'(fmul(64'(sz), 64'(sp)));
         a_czcp_ff <= fmul(64'(cz), 64'(cp));
         a_szcp_ff <= fmul(64'(sz), 64'(cp));
         a_szcx_ff <= fmul(64'(sz), 64'(cx));
         a_szsx_ff <= fmul(64'(sz), 64'(sx));
         a_czcx_ff <= fmul(64'(cz), 64'(cx));
         a_czsx_ff <= fmul(64'(cz), 64'(sx));
         a_cpsx_ff <= fmul(64'(cp), 64'(sx));
         a_cpcx_ff <= fmul(64'(cp), 64'(cx));
         a_msp_ff  <= -64'(sp);
         a_sx_ff   <= sx;
         a_cx_ff   <= cx;
         a_pose_ff <= pose;
      end
   end

   // stage B: second-level products, sums, saturation
   logic signed [31:0] b_rm_ff [3][3];
   pose_type           b_pose_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         b_rm_ff[0][0] <= sat32(a_czcp_ff);
         b_rm_ff[0][1] <= sat32(fmul(64'(a_czsp_ff), 64'(a_sx_ff)) - a_szcx_ff);
         b_rm_ff[0][2] <= sat32(fmul(64'(a_czsp_ff), 64'(a_cx_ff)) + a_szsx_ff);
         b_rm_ff[1][0] <= sat32(a_szcp_ff);
         b_rm_ff[1][1] <= sat32(fmul(64'(a_szsp_ff), 64'(a_sx_ff)) + a_czcx_ff);
         b_rm_ff[1][2] <= sat32(fmul(64'(a_szsp_ff), 64'(a_cx_ff)) - a_czsx_ff);
         b_rm_ff[2][0] <= sat32(a_msp_ff);
         b_rm_ff[2][1] <= sat32(a_cpsx_ff);
         b_rm_ff[2][2] <= sat32(a_cpcx_ff);
         b_pose_ff     <= a_pose_ff;
      end
   end

   // stage C: transpose and offset products
   logic signed [31:0] c_rm_ff [3][3];
   logic signed [63:0] c_prod_ff [3][3];
   pose_type           c_pose_ff;
   logic signed [31:0] off [3];

   always_comb begin
      off[0] = b_pose_ff.offset_x;
      off[1] = b_pose_ff.offset_y;
      off[2] = b_pose_ff.offset_z;
   end

   for (genvar r = 0; r < 3; r++) begin : g_r
      for (genvar c = 0; c < 3; c++) begin : g_c
         always_ff @(posedge clock) begin
            if (enable) begin
               c_rm_ff[r][c]   <= b_pose_ff.operation ? b_rm_ff[c][r] : b_rm_ff[r][c];
               c_prod_ff[r][c] <= 64'(off[c]) * 64'(b_rm_ff[c][r]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) c_pose_ff <= b_pose_ff;
   end

   // stage D: translation sum, round and saturate
   logic signed [31:0] offc [3];
   logic signed [65:0] acc [3];

   always_comb begin
      offc[0] = c_pose_ff.offset_x;
      offc[1] = c_pose_ff.offset_y;
      offc[2] = c_pose_ff.offset_z;
      for (int r = 0; r < 3; r++) begin
         acc[r] = -(66'(c_prod_ff[r][0]) + 66'(c_prod_ff[r][1]) + 66'(c_prod_ff[r][2]));
         acc[r] = (acc[r] + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_out
      always_ff @(posedge clock) begin
         if (enable) begin
            for (int c = 0; c < 3; c++) mat_out[r][c] <= c_rm_ff[r][c];
            if (c_pose_ff.operation)
               mat_out[r][3] <= (acc[r] > 66'sd2147483647) ? 32'sh7FFFFFFF :
                                (acc[r] < -66'sd2147483648) ? 32'sh80000000 : acc[r][31:0];
            else
               mat_out[r][3] <= offc[r];
         end
      end
   end

endmodule
`default_nettype wire
